// ===== rtl/core/ptd_pkg.sv =====
// Shared types and constants for the phase-angle TRIAC dimmer.
package ptd_pkg;

  localparam int TICK_WIDTH = 16;
  localparam int CFG_W      = 16;
  localparam int LEVEL_W    = 7;
  localparam int PROD_W     = LEVEL_W + CFG_W;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [CFG_W-1:0]   HALF_WAVE_RESET = 16'd10000;
  localparam logic [CFG_W-1:0]   PULSE_RESET     = 16'd100;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL      = 7'd100;

  // floor(x/100) ~ (x * RECIP) >> RECIP_SHIFT, low by at most one
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP = 16'd41943;
  localparam int SCALED_W    = PROD_W + RECIP_W;

  localparam logic CFG_HALF_WAVE  = 1'b0;
  localparam logic CFG_GATE_PULSE = 1'b1;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_ZC    = 2'd1,
    ACT_LEVEL = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_ZC_DELAY,
    OP_ZC_FULL,
    OP_HOLD
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [TICK_WIDTH-1:0] point;
  } ptd_cmd_t;

  typedef struct packed {
    logic gate;
    logic armed;
    logic pulse;
  } ptd_status_t;

endpackage

// ===== rtl/core/ptd_front.sv =====
// Front end: accepts items, tracks the dim level, computes the firing delay.
module ptd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [7:0]                in_level,
  input  logic [ptd_pkg::CFG_W-1:0] half_wave,
  output logic                      cmd_valid,
  output ptd_pkg::ptd_cmd_t         cmd,
  input  logic                      cmd_ready
);
  import ptd_pkg::*;

  logic [LEVEL_W-1:0]   level_r, level_nxt;
  logic                 s1_valid_r, s2_valid_r;
  op_t                  s1_op_r, s1_op_nxt, s2_op_r;
  logic [PROD_W-1:0]    s1_prod_r, s2_prod_r;
  logic [CFG_W-1:0]     s2_q0_r;
  logic [SCALED_W-1:0]  scaled;
  logic [PROD_W-1:0]    qx100, rem;
  logic [CFG_W-1:0]     quot, point;
  logic                 adv;

  assign adv       = !s2_valid_r || cmd_ready;
  assign in_ready  = adv;
  assign cmd_valid = s2_valid_r;

  always_comb begin
    level_nxt = level_r;
    s1_op_nxt = OP_HOLD;
    unique case (act_t'(in_action))
      ACT_TICK: s1_op_nxt = OP_TICK;
      ACT_ZC: begin
        if (level_r >= FULL_LEVEL) s1_op_nxt = OP_ZC_FULL;
        else if (level_r != '0)    s1_op_nxt = OP_ZC_DELAY;
      end
      ACT_LEVEL: begin
        level_nxt = (in_level > 8'(FULL_LEVEL)) ? FULL_LEVEL : in_level[LEVEL_W-1:0];
      end
      ACT_NONE: s1_op_nxt = OP_HOLD;
      default:  s1_op_nxt = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      if (in_valid) level_r <= level_nxt;
    end
  end

  assign scaled = SCALED_W'(s1_prod_r) * SCALED_W'(RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= s1_op_nxt;
      s1_prod_r <= PROD_W'(level_r) * PROD_W'(half_wave);
      s2_op_r   <= s1_op_r;
      s2_prod_r <= s1_prod_r;
      s2_q0_r   <= CFG_W'(scaled >> RECIP_SHIFT);
    end
  end

  assign qx100 = PROD_W'(s2_q0_r) * PROD_W'(100);
  assign rem   = s2_prod_r - qx100;
  assign quot  = s2_q0_r + CFG_W'(rem >= PROD_W'(100));
  assign point = half_wave - quot;

  assign cmd.op    = s2_op_r;
  assign cmd.point = TICK_WIDTH'(point);

endmodule

// ===== rtl/core/ptd_queue.sv =====
// Two-entry command queue between front and back.
module ptd_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_valid,
  output logic                       push_ready,
  input  ptd_pkg::ptd_cmd_t          push_cmd,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output ptd_pkg::ptd_cmd_t          pop_cmd,
  output logic [ptd_pkg::QCNT_W-1:0] fill
);
  import ptd_pkg::*;

  ptd_cmd_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;

  assign push_ready = cnt_r != QCNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign fill       = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== rtl/core/ptd_back.sv =====
// Back end: tick counter, gate alarm and result register.
module ptd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  ptd_pkg::ptd_cmd_t         cmd,
  input  logic [ptd_pkg::CFG_W-1:0] gate_pulse,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_gate,
  output logic                      out_alarm_armed,
  output ptd_pkg::ptd_status_t      status
);
  import ptd_pkg::*;

  logic [TICK_WIDTH-1:0] tick_r, tick_nxt, tick_inc;
  logic [TICK_WIDTH-1:0] point_r, point_nxt;
  logic                  armed_r, armed_nxt;
  logic                  pulse_r, pulse_nxt;
  logic                  gate_r, gate_nxt;
  logic                  out_valid_r;
  logic                  out_gate_r, out_armed_r;
  logic                  pop;

  assign cmd_ready = !out_valid_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign tick_inc  = tick_r + 1'b1;

  always_comb begin
    tick_nxt  = tick_r;
    point_nxt = point_r;
    armed_nxt = armed_r;
    pulse_nxt = pulse_r;
    gate_nxt  = gate_r;
    case (cmd.op)
      OP_TICK: begin
        tick_nxt = tick_inc;
        if (armed_r && tick_inc == point_r) begin
          if (!pulse_r) begin
            gate_nxt  = 1'b1;
            pulse_nxt = 1'b1;
            tick_nxt  = '0;
            point_nxt = TICK_WIDTH'(gate_pulse);
          end else begin
            gate_nxt  = 1'b0;
            pulse_nxt = 1'b0;
            armed_nxt = 1'b0;
          end
        end
      end
      OP_ZC_DELAY: begin
        tick_nxt  = '0;
        point_nxt = cmd.point;
        armed_nxt = 1'b1;
      end
      OP_ZC_FULL: begin
        gate_nxt  = 1'b1;
        tick_nxt  = '0;
        point_nxt = TICK_WIDTH'(gate_pulse);
        armed_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      point_r     <= TICK_WIDTH'(HALF_WAVE_RESET);
      armed_r     <= 1'b0;
      pulse_r     <= 1'b0;
      gate_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        tick_r  <= tick_nxt;
        point_r <= point_nxt;
        armed_r <= armed_nxt;
        pulse_r <= pulse_nxt;
        gate_r  <= gate_nxt;
      end
      if (cmd_ready) out_valid_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_gate_r  <= gate_nxt;
      out_armed_r <= armed_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_gate        = out_gate_r;
  assign out_alarm_armed = out_armed_r;

  assign status.gate  = gate_r;
  assign status.armed = armed_r;
  assign status.pulse = pulse_r;

endmodule

// ===== rtl/core/phase_angle_triac_dimmer_top.sv =====
// Top level of the phase-angle TRIAC dimmer: config registers, front, queue, back.
//
//   channel | ports                                   | direction
//   in      | in_valid/in_ready, in_action, in_level  | item in
//   out     | out_valid/out_ready, out_gate,          | result out
//           | out_alarm_armed                         |
//   cfg     | cfg_we, cfg_index, cfg_wdata            | register write
//
// One item per cycle sustained while out_ready does not stall the result.
// The front runs a registered delay pipeline (two multiplies, one correction).
// A two-entry queue and the result register let front and back stall apart.
// Synchronous active-low reset clears control state and loads register defaults.
module phase_angle_triac_dimmer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [7:0]                in_level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_gate,
  output logic                      out_alarm_armed,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ptd_pkg::CFG_W-1:0] cfg_wdata
);
  import ptd_pkg::*;

  logic [CFG_W-1:0] half_wave_r, gate_pulse_r;
  logic             f_valid, f_ready;
  ptd_cmd_t         f_cmd;
  logic             b_valid, b_ready;
  ptd_cmd_t         b_cmd;
  logic [QCNT_W-1:0] q_fill;
  ptd_status_t      st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_wave_r  <= HALF_WAVE_RESET;
      gate_pulse_r <= PULSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_WAVE:  half_wave_r  <= cfg_wdata;
        CFG_GATE_PULSE: gate_pulse_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ptd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_level  (in_level),
    .half_wave (half_wave_r),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  ptd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd),
    .fill       (q_fill)
  );

  ptd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (b_valid),
    .cmd_ready       (b_ready),
    .cmd             (b_cmd),
    .gate_pulse      (gate_pulse_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_gate        (out_gate),
    .out_alarm_armed (out_alarm_armed),
    .status          (st)
  );

`ifndef ASSERT_OFF
  a_pulse_armed: assert property (@(posedge clk) disable iff (!rst_n)
    st.pulse |-> st.armed)
    else $error("pulse active without armed alarm");

  a_release_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(st.gate) |-> (!st.armed && !st.pulse))
    else $error("gate released while alarm still pending");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_fill <= QCNT_W'(QDEPTH))
    else $error("command queue overflow");
`endif

endmodule

// ===== bench/gate_scoreboard_pkg.sv =====
// Scoreboard for the TRIAC dimmer: gate and alarm prediction plus result checking.
package gate_scoreboard_pkg;
  import ptd_pkg::*;

  typedef struct {
    bit gate;
    bit armed;
  } gate_view_t;

  class gate_scoreboard;
    logic [CFG_W-1:0]      half_wave;
    logic [CFG_W-1:0]      pulse_len;
    logic [LEVEL_W-1:0]    dim;
    logic [TICK_WIDTH-1:0] ticks;
    logic [TICK_WIDTH-1:0] alarm_at;
    bit                    armed;
    bit                    pulsing;
    bit                    gate;
    bit                    last_gate;
    gate_view_t            expected_gate_q[$];
    int                    errors;
    int                    results;
    int                    rises;

    function new();
      half_wave = HALF_WAVE_RESET;
      pulse_len = PULSE_RESET;
      dim       = '0;
      ticks     = '0;
      alarm_at  = HALF_WAVE_RESET;
      armed     = 1'b0;
      pulsing   = 1'b0;
      gate      = 1'b0;
      last_gate = 1'b0;
      errors    = 0;
      results   = 0;
      rises     = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] v);
      if (idx == CFG_HALF_WAVE) half_wave = v;
      else pulse_len = v;
    endfunction

    function void fire_alarm();
      if (!pulsing) begin
        gate     = 1'b1;
        pulsing  = 1'b1;
        ticks    = '0;
        alarm_at = pulse_len;
      end else begin
        gate    = 1'b0;
        pulsing = 1'b0;
        armed   = 1'b0;
      end
    endfunction

    function void note_item(act_t act, logic [7:0] lv);
      int unsigned part;
      gate_view_t  v;
      case (act)
        ACT_TICK: begin
          ticks = ticks + 1'b1;
          if (armed && ticks == alarm_at) fire_alarm();
        end
        ACT_ZC: begin
          if (dim != '0 && dim < FULL_LEVEL) begin
            part     = (32'(dim) * 32'(half_wave)) / 32'(FULL_LEVEL);
            ticks    = '0;
            alarm_at = half_wave - part[CFG_W-1:0];
            armed    = 1'b1;
          end else if (dim >= FULL_LEVEL) begin
            gate     = 1'b1;
            ticks    = '0;
            alarm_at = pulse_len;
            armed    = 1'b1;
          end
        end
        ACT_LEVEL: dim = (lv > 8'(FULL_LEVEL)) ? FULL_LEVEL : lv[LEVEL_W-1:0];
        default: ;
      endcase
      v.gate  = gate;
      v.armed = armed;
      expected_gate_q.push_back(v);
    endfunction

    function int pending();
      return expected_gate_q.size();
    endfunction

    task report(string what);
      $display("mismatch %0d: %s", errors + 1, what);
      errors++;
    endtask

    task check_gate(bit g, bit a);
      gate_view_t v;
      results++;
      if (g && !last_gate) rises++;
      last_gate = g;
      if (expected_gate_q.size() == 0) begin
        report($sformatf("result gate=%0d armed=%0d with nothing pending", g, a));
      end else begin
        v = expected_gate_q.pop_front();
        if (g != v.gate)
          report($sformatf("result %0d: gate %0d, predicted %0d", results, g, v.gate));
        if (a != v.armed)
          report($sformatf("result %0d: alarm_armed %0d, predicted %0d", results, a, v.armed));
      end
    endtask
  endclass

endpackage

// ===== bench/tb_phase_angle_triac_dimmer_top.sv =====
// Testbench for the phase-angle TRIAC dimmer: directed and random items, scoreboard check.
module tb_phase_angle_triac_dimmer_top;
  import ptd_pkg::*;
  import gate_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1850;
  localparam int TICK_CAP    = 700;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       in_action;
  logic [7:0]       in_level;
  logic             out_valid;
  logic             out_ready;
  logic             out_gate;
  logic             out_alarm_armed;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  gate_scoreboard sb;
  bit             steady;
  int             items_sent;
  int             cycle_cnt;
  int             phase;

  phase_angle_triac_dimmer_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_level        (in_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_gate        (out_gate),
    .out_alarm_armed (out_alarm_armed),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_gate(out_gate, out_alarm_armed);
  end

  task automatic send_item(act_t a, logic [7:0] lv);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 23) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= a;
    in_level  <= lv;
    do @(posedge clk); while (!in_ready);
    sb.note_item(a, lv);
    items_sent++;
    @(negedge clk);
  endtask

  // hold off until every pending result is out, then let the pipe settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] hw, logic [CFG_W-1:0] pl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HALF_WAVE;
    cfg_wdata <= hw;
    sb.write_reg(CFG_HALF_WAVE, hw);
    @(negedge clk);
    cfg_index <= CFG_GATE_PULSE;
    cfg_wdata <= pl;
    sb.write_reg(CFG_GATE_PULSE, pl);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_noise(int n);
    repeat (n) send_item(act_t'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  // level, zero cross, then ticks to see the firing and the release, capped by TICK_CAP and the item budget
  task automatic run_sequence();
    logic [7:0] lv;
    int         n;
    lv = ($urandom_range(99) < 20) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 100));
    send_item(ACT_LEVEL, lv);
    send_item(ACT_ZC, 8'($urandom_range(255)));
    n = int'(sb.alarm_at) + int'(sb.pulse_len) + $urandom_range(8);
    if (n > TICK_CAP) n = TICK_CAP;
    if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
    if (n < 0) n = 0;
    repeat (n) begin
      if ($urandom_range(99) < 4) send_noise(1);
      send_item(ACT_TICK, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] hw;
    logic [CFG_W-1:0] pl;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_action  = ACT_TICK;
    in_level   = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_HALF_WAVE;
    cfg_wdata  = '0;
    steady     = 1'b0;
    items_sent = 0;
    cycle_cnt  = 0;
    phase      = 0;
    sb         = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register defaults: full level, saturation, level zero, unused action
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_NONE, 8'hFF);
    send_item(ACT_LEVEL, 8'hFF);
    send_item(ACT_ZC, 8'h00);
    repeat (3) send_item(ACT_TICK, 8'hAA);
    send_item(ACT_LEVEL, 8'h00);
    send_item(ACT_ZC, 8'h55);
    send_item(ACT_LEVEL, 8'd101);
    send_item(ACT_LEVEL, 8'd99);
    send_item(ACT_ZC, 8'h00);
    repeat (2) send_item(ACT_TICK, 8'h00);

    // shortest half wave and pulse
    drain_pipe();
    program_regs(16'd1, 16'd1);
    send_item(ACT_LEVEL, 8'd1);
    send_item(ACT_ZC, 8'h00);
    repeat (2) send_item(ACT_TICK, 8'h00);
    send_item(ACT_LEVEL, 8'd99);
    send_item(ACT_ZC, 8'h00);
    repeat (2) send_item(ACT_TICK, 8'h00);
    send_item(ACT_LEVEL, 8'd100);
    send_item(ACT_ZC, 8'h00);
    repeat (3) send_item(ACT_TICK, 8'h00);

    while (items_sent < ITEM_TARGET) begin
      phase++;
      steady = (phase == 4 || phase == 5);
      drain_pipe();
      if (phase % 6 == 0) begin
        hw = $urandom_range(1) ? 16'hFFFF : 16'd1;
        pl = $urandom_range(1) ? 16'hFFFF : 16'd1;
      end else begin
        hw = 16'($urandom_range(1, 150));
        pl = 16'($urandom_range(1, 30));
      end
      program_regs(hw, pl);
      repeat (3) begin
        if (items_sent < ITEM_TARGET) begin
          if ($urandom_range(99) < 80) run_sequence();
          else send_noise($urandom_range(10, 30));
        end
      end
    end

    steady = 1'b0;
    drain_pipe();
    repeat (12) @(negedge clk);
    if (sb.pending() != 0) sb.report("predicted results never arrived");
    $display("run covered %0d items over %0d register settings, %0d results checked",
             items_sent, phase + 2, sb.results);
    $display("gate pulses observed: %0d, mismatches: %0d", sb.rises, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ptd_pkg.sv
rtl/core/ptd_front.sv
rtl/core/ptd_queue.sv
rtl/core/ptd_back.sv
rtl/core/phase_angle_triac_dimmer_top.sv
bench/gate_scoreboard_pkg.sv
bench/tb_phase_angle_triac_dimmer_top.sv
